>>> sv/sem_pkg.sv
package sem_pkg;

	localparam int GRAD_W = 11;
	localparam int SQ_W = 20;
	localparam int SUM_W = 21;
	localparam int POS_W = 11;
	localparam int PIX_W = 8;
	localparam int CFG_W = 12;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int HEIGHT_LIMIT = 2048;
	localparam logic [CFG_W-1:0] SIZE_MIN = 12'd3;

	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// One interior pixel waiting for its magnitude.
	typedef struct packed {
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic frame_end;
	} sem_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} sem_qstat_t;

	typedef enum logic [4:0] {
		B_IDLE   = 5'b00001,
		B_SQUARE = 5'b00010,
		B_SUM    = 5'b00100,
		B_ROOT   = 5'b01000,
		B_DONE   = 5'b10000
	} sem_bstate_t;

endpackage

>>> sv/sem_front.sv
module sem_front import sem_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [PIX_W-1:0] pixel,
	input  logic frame_start,
	input  logic [CFG_W-1:0] image_width,
	input  logic [CFG_W-1:0] image_height,
	input  sem_qstat_t q_stat,
	output logic push,
	output sem_item_t push_item
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
	logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

	logic [CW-1:0] col_q;
	logic [POS_W-1:0] row_q;
	logic pend_q;
	logic [CW-1:0] col_s1;
	logic [POS_W-1:0] row_s1;
	logic [PIX_W-1:0] px_s1;
	logic [PIX_W-1:0] upper_rd_s1;
	logic [PIX_W-1:0] middle_rd_s1;
	logic [PIX_W-1:0] win_q [9];

	logic accept;
	logic go;
	logic interior;
	logic [CW-1:0] cur_col;
	logic [POS_W-1:0] cur_row;
	logic [CW-1:0] nxt_col;
	logic [POS_W-1:0] nxt_row;
	logic [PIX_W-1:0] nw [9];
	logic [9:0] sum_a;
	logic [9:0] sum_b;
	logic [9:0] sum_c;
	logic [9:0] sum_d;

	assign in_ready = !pend_q;
	assign accept = in_valid && !pend_q;

	// Position of the incoming pixel, then the position after it.
	always_comb begin
		logic [CW-1:0] c0;
		logic [CFG_W-1:0] r0;
		logic [CW:0] cn;
		logic [CFG_W-1:0] rn;
		c0 = frame_start ? '0 : col_q;
		r0 = frame_start ? '0 : {1'b0, row_q};
		if ({1'b0, c0} >= image_width) begin
			c0 = '0;
			r0 = r0 + 12'd1;
		end
		if (r0 >= image_height) begin
			r0 = '0;
		end
		cur_col = c0;
		cur_row = POS_W'(r0);
		cn = {1'b0, c0} + 1'b1;
		rn = r0;
		if (cn >= image_width) begin
			cn = '0;
			rn = r0 + 12'd1;
			if (rn >= image_height) begin
				rn = '0;
			end
		end
		nxt_col = CW'(cn);
		nxt_row = POS_W'(rn);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (accept) begin
				col_q <= nxt_col;
				row_q <= nxt_row;
				pend_q <= 1'b1;
			end else if (go) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1 <= cur_col;
			row_s1 <= cur_row;
			px_s1 <= pixel;
		end
	end

	// Line stores: read when a pixel is taken, written back when the window shifts.
	always_ff @(posedge clk) begin
		if (accept) begin
			upper_rd_s1 <= upper_mem[cur_col];
			middle_rd_s1 <= middle_mem[cur_col];
		end
		if (go) begin
			upper_mem[col_s1] <= middle_rd_s1;
			middle_mem[col_s1] <= px_s1;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nw[i*3] = win_q[i*3+1];
			nw[i*3+1] = win_q[i*3+2];
		end
		nw[2] = upper_rd_s1;
		nw[5] = middle_rd_s1;
		nw[8] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (go) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= nw[i];
			end
		end
	end

	assign interior = (col_s1 >= CW'(2)) && (row_s1 >= POS_W'(2));
	assign go = pend_q && (!interior || !q_stat.full);
	assign push = go && interior;

	assign sum_a = 10'(nw[0]) + {1'b0, nw[3], 1'b0} + 10'(nw[6]);
	assign sum_b = 10'(nw[2]) + {1'b0, nw[5], 1'b0} + 10'(nw[8]);
	assign sum_c = 10'(nw[0]) + {1'b0, nw[1], 1'b0} + 10'(nw[2]);
	assign sum_d = 10'(nw[6]) + {1'b0, nw[7], 1'b0} + 10'(nw[8]);

	always_comb begin
		push_item.gx = $signed({1'b0, sum_a}) - $signed({1'b0, sum_b});
		push_item.gy = $signed({1'b0, sum_c}) - $signed({1'b0, sum_d});
		push_item.col = POS_W'(32'(col_s1) - 32'd1);
		push_item.row = row_s1 - POS_W'(1);
		push_item.frame_end = (({1'b0, col_s1} + 1'b1) == image_width)
			&& (({1'b0, row_s1} + 12'd1) == image_height);
	end

endmodule

>>> sv/sem_queue.sv
module sem_queue import sem_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  sem_item_t push_item,
	input  logic pop,
	output sem_item_t head,
	output sem_qstat_t stat
);

	sem_item_t slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] count_q;

	assign stat.full = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/sem_back.sv
module sem_back import sem_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  sem_qstat_t q_stat,
	input  sem_item_t head,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] magnitude,
	output logic [POS_W-1:0] col,
	output logic [POS_W-1:0] row,
	output logic frame_end
);

	sem_bstate_t state_q;
	sem_item_t item_q;
	logic [SQ_W-1:0] sqx_q;
	logic [SQ_W-1:0] sqy_q;
	logic [SUM_W-1:0] sum_q;
	logic [7:0] root_q;
	logic [7:0] bit_q;
	logic out_valid_q;
	logic [7:0] mag_q;
	logic [POS_W-1:0] col_q;
	logic [POS_W-1:0] row_q;
	logic fend_q;

	logic signed [2*GRAD_W-1:0] px2;
	logic signed [2*GRAD_W-1:0] py2;
	logic [7:0] trial;
	logic [15:0] trial2;
	logic load_out;

	assign pop = (state_q == B_IDLE) && !q_stat.empty;
	assign px2 = item_q.gx * item_q.gx;
	assign py2 = item_q.gy * item_q.gy;
	assign trial = root_q | bit_q;
	assign trial2 = trial * trial;
	assign load_out = (state_q == B_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!q_stat.empty) begin
						state_q <= B_SQUARE;
					end
				end
				B_SQUARE: state_q <= B_SUM;
				B_SUM: state_q <= B_ROOT;
				B_ROOT: begin
					if (bit_q[0] || (sum_q[SUM_W-1:16] != '0)) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (load_out) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
		if (state_q == B_SQUARE) begin
			sqx_q <= SQ_W'(px2);
			sqy_q <= SQ_W'(py2);
		end
		if (state_q == B_SUM) begin
			sum_q <= SUM_W'(sqx_q) + SUM_W'(sqy_q);
			root_q <= '0;
			bit_q <= 8'h80;
		end
		// One result bit per cycle; a sum of 65536 or more saturates.
		if (state_q == B_ROOT) begin
			if (sum_q[SUM_W-1:16] != '0) begin
				root_q <= 8'hFF;
			end else if (trial2 <= sum_q[15:0]) begin
				root_q <= trial;
			end
			bit_q <= bit_q >> 1;
		end
		if (load_out) begin
			mag_q <= root_q;
			col_q <= item_q.col;
			row_q <= item_q.row;
			fend_q <= item_q.frame_end;
		end
	end

	assign out_valid = out_valid_q;
	assign magnitude = mag_q;
	assign col = col_q;
	assign row = row_q;
	assign frame_end = fend_q;

endmodule

>>> sv/sobel_edge_magnitude_3x3.sv
// Sobel 3x3 gradient magnitude over a raster-order stream of 8-bit pixels.
// Pixels enter on the in_valid/in_ready channel, one transfer per pixel, with
// frame_start marking the first pixel of a frame. Each interior pixel (not on
// the outer ring of the image) yields one transfer on the out_valid/out_ready
// channel carrying floor(sqrt(gx^2 + gy^2)) saturated at 255, its column and
// line, and frame_end on the last interior result of the frame. Border pixels
// yield nothing.
// The front takes one pixel at a time: the line store read is registered as
// the pixel is taken, then a second step shifts the window, writes the stores
// back and forms gx and gy, held off for an interior pixel by a full queue.
// The back handles one result at a time (pop, square, sum, eight root bits,
// output load) and skips the remaining root bits when the root saturates.
// The back sets the interior rate.
// A four-entry queue between front and back buffers the interior results.
// When the receiver stalls, the result waits in the output register, the
// back holds, the queue fills and then in_ready drops.
// Reset clears counters, window and queue; width and height go to 640 and
// 480; line stores are not cleared, a frame's first two lines fill them before
// they are read. The user must write size registers on the cfg channel
// (index 0 width, index 1 height) only while the block is idle; not enforced.
module sobel_edge_magnitude_3x3 import sem_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] pixel,
	input  logic frame_start,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] magnitude,
	output logic [10:0] col,
	output logic [10:0] row,
	output logic frame_end,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [11:0] cfg_data
);

	localparam int WIDTH_RESET = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [CFG_W-1:0] cfg_sat;

	logic q_push;
	logic q_pop;
	sem_item_t q_in;
	sem_item_t q_head;
	sem_qstat_t q_stat;

	assign cfg_ready = 1'b1;

	// Size values are clamped into their legal range as they are written.
	always_comb begin
		cfg_sat = cfg_data;
		if (cfg_sat < SIZE_MIN) begin
			cfg_sat = SIZE_MIN;
		end
		unique case (cfg_index)
			REG_WIDTH: begin
				if (32'(cfg_sat) > MAX_WIDTH) begin
					cfg_sat = CFG_W'(MAX_WIDTH);
				end
			end
			REG_HEIGHT: begin
				if (32'(cfg_sat) > HEIGHT_LIMIT) begin
					cfg_sat = CFG_W'(HEIGHT_LIMIT);
				end
			end
			default: cfg_sat = cfg_data;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CFG_W'(WIDTH_RESET);
			height_q <= 12'd480;
		end else if (cfg_valid) begin
			if (cfg_index == REG_WIDTH) begin
				width_q <= cfg_sat;
			end else begin
				height_q <= cfg_sat;
			end
		end
	end

	sem_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel(pixel),
		.frame_start(frame_start),
		.image_width(width_q),
		.image_height(height_q),
		.q_stat(q_stat),
		.push(q_push),
		.push_item(q_in)
	);

	sem_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_item(q_in),
		.pop(q_pop),
		.head(q_head),
		.stat(q_stat)
	);

	sem_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_stat(q_stat),
		.head(q_head),
		.pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.magnitude(magnitude),
		.col(col),
		.row(row),
		.frame_end(frame_end)
	);

	// The front never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_stat.full))
		else $error("queue push while full");

	// The back never pops an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_stat.empty))
		else $error("queue pop while empty");

	// After a pixel transfer the front is busy with the store write-back.
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("front took a pixel during write-back");

endmodule
